// ===== src/bbmq_pkg.sv =====
// shared types, codes and constants of the byte budget message queue
package bbmq_pkg;

  // field widths of the request and result items
  localparam int OPCODE_W = 2;
  localparam int SIZE_W   = 32;
  localparam int HANDLE_W = 64;
  localparam int PID_W    = 6;
  localparam int STATUS_W = 2;
  localparam int PTOT_W   = 7;

  // configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;

  // default sizing
  localparam int DEF_SLOT_DEPTH    = 64;
  localparam int DEF_MAX_PRODUCERS = 64;

  // reset values of the configuration registers
  localparam logic [SIZE_W-1:0] CAPACITY_RST = 32'd65536;
  localparam logic [PTOT_W-1:0] PTOTAL_RST   = 7'd1;

  // register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CAPACITY = 1'b0,
    CFG_PTOTAL   = 1'b1
  } cfg_idx_t;

  // request opcodes
  typedef enum logic [OPCODE_W-1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_FINISH = 2'd2,
    OP_QUERY  = 2'd3
  } op_t;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_DONE    = 2'd0,
    ST_REFUSED = 2'd1,
    ST_DROPPED = 2'd2,
    ST_WOULDBL = 2'd3
  } status_t;

  // one message descriptor
  typedef struct packed {
    logic [HANDLE_W-1:0] handle;
    logic [SIZE_W-1:0]   size;
  } desc_t;

  // producer tracker status toward the queue control
  typedef struct packed {
    logic closed;
    logic closed_nxt;
  } prod_stat_t;

endpackage

// ===== src/bbmq_if.sv =====
// request and result channel interfaces of the byte budget message queue
interface bbmq_in_if;
  import bbmq_pkg::*;
  logic                valid;
  logic                ready;
  logic [OPCODE_W-1:0] opcode;
  logic [SIZE_W-1:0]   msg_size;
  logic [HANDLE_W-1:0] msg_handle;
  logic                blocking;
  logic [PID_W-1:0]    finisher_id;

  modport source (output valid, opcode, msg_size, msg_handle, blocking, finisher_id,
                  input ready);
  modport sink   (input valid, opcode, msg_size, msg_handle, blocking, finisher_id,
                  output ready);
endinterface

interface bbmq_out_if;
  import bbmq_pkg::*;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [SIZE_W-1:0]   moved_size;
  logic [HANDLE_W-1:0] out_handle;
  logic                queue_empty;
  logic                empty_and_closed;

  modport source (output valid, status, moved_size, out_handle, queue_empty,
                  empty_and_closed, input ready);
  modport sink   (input valid, status, moved_size, out_handle, queue_empty,
                  empty_and_closed, output ready);
endinterface

// ===== src/bbmq_slot_store.sv =====
// descriptor memory with a registered prefetch of the next head entry
module bbmq_slot_store #(
  parameter int SLOT_DEPTH = bbmq_pkg::DEF_SLOT_DEPTH,
  parameter int PTR_W      = $clog2(SLOT_DEPTH)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 wr_en,
  input  logic [PTR_W-1:0]     wr_addr,
  input  bbmq_pkg::desc_t      wr_data,
  input  logic [PTR_W-1:0]     rd_addr,
  output bbmq_pkg::desc_t      head_data
);
  import bbmq_pkg::*;

  desc_t mem [SLOT_DEPTH];
  desc_t rd_data_r;
  desc_t byp_data_r;
  logic  byp_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, addressed by the head pointer of the next cycle
  always_ff @(posedge clk) begin
    rd_data_r  <= mem[rd_addr];
    byp_data_r <= wr_data;
  end

  // a write into the slot being prefetched wins over the old contents
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byp_r <= 1'b0;
    end else begin
      byp_r <= wr_en && (wr_addr == rd_addr);
    end
  end

  assign head_data = byp_r ? byp_data_r : rd_data_r;

endmodule

// ===== src/bbmq_prod_track.sv =====
// finished producer map, finished count and closed flag
module bbmq_prod_track #(
  parameter int MAX_PRODUCERS = bbmq_pkg::DEF_MAX_PRODUCERS
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        mark_en,
  input  logic [bbmq_pkg::PID_W-1:0]  pid,
  input  logic [bbmq_pkg::PTOT_W-1:0] ptotal,
  output bbmq_pkg::prod_stat_t        stat
);
  import bbmq_pkg::*;

  logic [MAX_PRODUCERS-1:0] fin_map_r, fin_map_nxt;
  logic [MAX_PRODUCERS-1:0] hit;
  logic [PTOT_W-1:0]        fin_cnt_r, fin_cnt_nxt;
  logic                     new_mark;

  // decode the producer id; ids past the map hit nothing
  always_comb begin
    for (int i = 0; i < MAX_PRODUCERS; i++) begin
      hit[i] = (pid == PID_W'(i));
    end
  end

  // only a first mark of a producer counts
  always_comb begin
    new_mark    = mark_en && |(hit & ~fin_map_r);
    fin_map_nxt = new_mark ? (fin_map_r | hit) : fin_map_r;
    fin_cnt_nxt = new_mark ? fin_cnt_r + 1'b1 : fin_cnt_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fin_map_r <= '0;
      fin_cnt_r <= '0;
    end else begin
      fin_map_r <= fin_map_nxt;
      fin_cnt_r <= fin_cnt_nxt;
    end
  end

  // closed once enough distinct producers are done
  assign stat.closed     = (fin_cnt_r >= ptotal);
  assign stat.closed_nxt = (fin_cnt_nxt >= ptotal);

endmodule

// ===== src/byte_budget_message_queue_unit.sv =====
// top level of the byte budget message queue: control, counters and result register
//
// Usage: requests arrive on in_chan (valid/ready), each carrying an opcode
// (add, remove, producer finished, status query) and its operands. Every
// request yields exactly one result on out_chan: a status, the moved size,
// the removed handle and the empty / empty-and-closed flags after the step.
// A request accepted at one edge is executed at that edge and its result
// is valid from the next cycle on. Throughput is one request per cycle
// while results are drained; the next head descriptor is prefetched from
// the slot memory every cycle, so back-to-back removes do not wait for a read.
// The result register parts the two sides: in_chan.ready is high while the
// result register is empty or being drained, so a stalled receiver holds
// its result and stops intake after one request.
// Reset (rst_n, synchronous) empties the queue, clears the finished
// producers and loads a capacity of 65536 bytes and a producer total of 1.
// The descriptor memory needs no clearing. Configuration writes through
// cfg_we / cfg_index / cfg_wdata take effect at once and are meant for
// idle periods.
module byte_budget_message_queue_unit #(
  parameter int SLOT_DEPTH    = bbmq_pkg::DEF_SLOT_DEPTH,
  parameter int MAX_PRODUCERS = bbmq_pkg::DEF_MAX_PRODUCERS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  bbmq_in_if.sink                         in_chan,
  bbmq_out_if.source                      out_chan,
  input  logic                            cfg_we,
  input  logic [bbmq_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bbmq_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import bbmq_pkg::*;

  localparam int PTR_W = $clog2(SLOT_DEPTH);
  localparam int CNT_W = $clog2(SLOT_DEPTH + 1);

  // configuration registers
  logic [SIZE_W-1:0] capacity_r;
  logic [PTOT_W-1:0] ptotal_r;

  // queue state
  logic [PTR_W-1:0]  head_r, head_nxt;
  logic [PTR_W-1:0]  tail_r, tail_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [SIZE_W-1:0] held_r, held_nxt;

  // result register
  logic                out_valid_r;
  status_t             status_r;
  logic [SIZE_W-1:0]   moved_r;
  logic [HANDLE_W-1:0] handle_r;
  logic                empty_r;
  logic                eac_r;

  // combinational step
  logic                accept;
  op_t                 op;
  status_t             status_nxt;
  logic [SIZE_W-1:0]   moved_nxt;
  logic [HANDLE_W-1:0] handle_nxt;
  logic [SIZE_W-1:0]   free_bytes;
  logic                wr_en;
  logic                mark_en;
  desc_t               wr_data;
  desc_t               head_data;
  prod_stat_t          pstat;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r <= CAPACITY_RST;
      ptotal_r   <= PTOTAL_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_CAPACITY: capacity_r <= cfg_wdata;
        CFG_PTOTAL:   ptotal_r   <= cfg_wdata[PTOT_W-1:0];
        default: ;
      endcase
    end
  end

  // handshake
  assign in_chan.ready = !out_valid_r || out_chan.ready;
  assign accept        = in_chan.valid && in_chan.ready;
  assign op            = op_t'(in_chan.opcode);

  assign free_bytes = (capacity_r > held_r) ? capacity_r - held_r : '0;
  assign wr_data    = '{handle: in_chan.msg_handle, size: in_chan.msg_size};

  // execute one request
  always_comb begin
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    cnt_nxt    = cnt_r;
    held_nxt   = held_r;
    status_nxt = ST_DONE;
    moved_nxt  = '0;
    handle_nxt = '0;
    wr_en      = 1'b0;
    mark_en    = 1'b0;
    if (accept) begin
      unique case (op)
        OP_ADD: begin
          if (in_chan.msg_size == '0 || in_chan.msg_size > capacity_r || pstat.closed) begin
            status_nxt = ST_REFUSED;
          end else if (in_chan.msg_size > free_bytes || cnt_r == CNT_W'(SLOT_DEPTH)) begin
            status_nxt = in_chan.blocking ? ST_WOULDBL : ST_DROPPED;
          end else begin
            wr_en     = 1'b1;
            tail_nxt  = (tail_r == PTR_W'(SLOT_DEPTH - 1)) ? '0 : tail_r + 1'b1;
            cnt_nxt   = cnt_r + 1'b1;
            held_nxt  = held_r + in_chan.msg_size;
            moved_nxt = in_chan.msg_size;
          end
        end
        OP_REMOVE: begin
          if (cnt_r == '0) begin
            if (!in_chan.blocking) begin
              status_nxt = ST_DROPPED;
            end else begin
              status_nxt = pstat.closed ? ST_REFUSED : ST_WOULDBL;
            end
          end else begin
            handle_nxt = head_data.handle;
            moved_nxt  = head_data.size;
            head_nxt   = (head_r == PTR_W'(SLOT_DEPTH - 1)) ? '0 : head_r + 1'b1;
            cnt_nxt    = cnt_r - 1'b1;
            held_nxt   = (held_r >= head_data.size) ? held_r - head_data.size : '0;
          end
        end
        OP_FINISH: mark_en = 1'b1;
        OP_QUERY:  ;
        default:   ;
      endcase
    end
  end

  // queue state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      cnt_r  <= '0;
      held_r <= '0;
    end else begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      cnt_r  <= cnt_nxt;
      held_r <= held_nxt;
    end
  end

  // result register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // result register payload
  always_ff @(posedge clk) begin
    if (accept) begin
      status_r <= status_nxt;
      moved_r  <= moved_nxt;
      handle_r <= handle_nxt;
      empty_r  <= (cnt_nxt == '0);
      eac_r    <= (cnt_nxt == '0) && pstat.closed_nxt;
    end
  end

  assign out_chan.valid            = out_valid_r;
  assign out_chan.status           = status_r;
  assign out_chan.moved_size       = moved_r;
  assign out_chan.out_handle       = handle_r;
  assign out_chan.queue_empty      = empty_r;
  assign out_chan.empty_and_closed = eac_r;

  // descriptor memory
  bbmq_slot_store #(
    .SLOT_DEPTH (SLOT_DEPTH),
    .PTR_W      (PTR_W)
  ) u_store (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_en     (wr_en),
    .wr_addr   (tail_r),
    .wr_data   (wr_data),
    .rd_addr   (head_nxt),
    .head_data (head_data)
  );

  // producer tracking
  bbmq_prod_track #(
    .MAX_PRODUCERS (MAX_PRODUCERS)
  ) u_prod (
    .clk     (clk),
    .rst_n   (rst_n),
    .mark_en (mark_en),
    .pid     (in_chan.finisher_id),
    .ptotal  (ptotal_r),
    .stat    (pstat)
  );

  // occupancy never passes the slot count
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(SLOT_DEPTH))
    else $error("entry count above slot depth");

  // an empty queue holds no bytes
  a_empty_bytes: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == '0) |-> (held_r == '0))
    else $error("bytes held while empty");

  // an empty queue has its pointers together
  a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == '0) |-> (head_r == tail_r))
    else $error("pointers apart while empty");

  // a completed add grows the queue by one entry
  a_add_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && op == OP_ADD && status_nxt == ST_DONE) |=> (cnt_r == $past(cnt_r) + 1'b1))
    else $error("completed add did not grow the queue");

endmodule
